/* sv/tmp_pkg.sv */
package tmp_pkg;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
    localparam int DT_FRAC = 16;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ACCEL  = 3'd1;
    localparam logic [2:0] PH_CRUISE = 3'd2;
    localparam logic [2:0] PH_DECEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_IDLE   = 2'd2;

    localparam logic [2:0] REG_TDIST = 3'd0;
    localparam logic [2:0] REG_VMAX  = 3'd1;
    localparam logic [2:0] REG_ARATE = 3'd2;
    localparam logic [2:0] REG_SPOS  = 3'd3;
    localparam logic [2:0] REG_PTOL  = 3'd4;
    localparam logic [2:0] REG_VTOL  = 3'd5;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;
    localparam logic [3:0] OP_SMUL   = 4'd2;
    localparam logic [3:0] OP_SFIN   = 4'd3;
    localparam logic [3:0] OP_SQMUL  = 4'd4;
    localparam logic [3:0] OP_SQFIN  = 4'd5;
    localparam logic [3:0] OP_UMUL   = 4'd6;
    localparam logic [3:0] OP_UFIN   = 4'd7;
    localparam logic [3:0] OP_UAPPLY = 4'd8;
    localparam logic [3:0] OP_EMUL   = 4'd9;
    localparam logic [3:0] OP_EFIN   = 4'd10;
    localparam logic [3:0] OP_OUT    = 4'd11;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_cmd;
        logic       upd_run;
        logic       div_done;
        logic       sq_done;
        logic       need_sqrt;
        logic       est_run;
        logic       out_free;
    } sts_t;

    typedef struct packed {
        logic [31:0] tdist;
        logic [31:0] vmax;
        logic [31:0] arate;
        logic [31:0] spos;
        logic [30:0] ptol;
        logic [30:0] vtol;
    } cfg_t;

    function automatic logic [30:0] mag32(input logic [31:0] v);
        logic [31:0] n;
        n = 32'd0 - v;
        if (!v[31])
            return v[30:0];
        else if (n[31])
            return MAX31;
        else
            return n[30:0];
    endfunction

    function automatic logic [30:0] sat31(input logic [63:0] q);
        return (|q[63:31]) ? MAX31 : q[30:0];
    endfunction

endpackage

/* sv/tmp_div.sv */
module tmp_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [63:0] quo_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 6'd63;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* sv/tmp_sqrt.sv */
module tmp_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [31:0] root
);
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 5'd31;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // digit-by-digit root, two operand bits per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= operand;
            r_reg   <= 64'd0;
            bit_reg <= 64'd1 << 62;
        end
        else if (run_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];
endmodule

/* sv/tmp_datapath.sv */
module tmp_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  tmp_pkg::cmd_t  ctl,
    output tmp_pkg::sts_t  sts,
    input  tmp_pkg::cfg_t  cfg,
    input  logic [55:0]    in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [103:0]   out_data
);
    import tmp_pkg::*;

    logic [31:0] pos_reg;
    logic [15:0] dt_reg;
    logic [30:0] vmax_reg;
    logic [30:0] step_reg;
    logic [32:0] dist_reg;
    logic [33:0] rem_reg;
    logic [30:0] est_reg;

    logic [2:0]  phase_reg;
    logic [30:0] velocity_reg;
    logic [31:0] accel_out_reg;
    logic [30:0] ramp_span_reg;
    logic [30:0] cruise_span_reg;
    logic [30:0] peak_reg;
    logic [30:0] move_length_reg;
    logic [30:0] accel_mag_reg;

    logic        m_valid_reg;
    logic [103:0] m_data_reg;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_q;
    logic [30:0] q_sat;
    logic        sq_start;
    logic [63:0] sq_operand;
    logic        sq_done;
    logic [31:0] sq_root;

    logic [61:0] vmax_sq;
    logic [61:0] vel_sq;
    logic [61:0] len_vel;
    logic [61:0] amag_ramp;

    logic [32:0] d_diff;
    logic [32:0] d_abs;
    logic [46:0] step_prod;
    logic        ramp_fits;
    logic [31:0] ramp_end;
    logic [2:0]  phase_next;
    logic [31:0] vsum;
    logic        upd_run;
    logic        est_run;

    assign q_sat   = sat31(div_q);
    assign upd_run = (phase_reg == PH_ACCEL) || (phase_reg == PH_CRUISE)
                     || (phase_reg == PH_DECEL);
    assign est_run = upd_run && (peak_reg != 31'd0);

    assign vmax_sq   = vmax_reg * vmax_reg;
    assign vel_sq    = velocity_reg * velocity_reg;
    assign len_vel   = move_length_reg * velocity_reg;
    assign amag_ramp = accel_mag_reg * ramp_span_reg;

    assign d_diff    = {pos_reg[31], pos_reg} - {cfg.spos[31], cfg.spos};
    assign d_abs     = d_diff[32] ? (33'd0 - d_diff) : d_diff;
    assign step_prod = accel_mag_reg * dt_reg;
    assign ramp_fits = {q_sat, 1'b0} <= {1'b0, move_length_reg};
    assign ramp_end  = {1'b0, ramp_span_reg} + {1'b0, cruise_span_reg};
    assign vsum      = {1'b0, velocity_reg} + {1'b0, step_reg};

    // shared divider: ramp span, braking distance and remaining estimate
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = 64'd0;
        div_divisor  = {accel_mag_reg, 1'b0};
        unique case (ctl.op)
            OP_SMUL:
            begin
                div_start    = 1'b1;
                div_dividend = {2'b0, vmax_sq};
            end
            OP_UMUL:
            begin
                div_start    = 1'b1;
                div_dividend = {2'b0, vel_sq};
            end
            OP_EMUL:
            begin
                div_start    = est_run;
                div_dividend = {2'b0, len_vel};
                div_divisor  = {1'b0, peak_reg};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sq_start   = (ctl.op == OP_SQMUL);
    assign sq_operand = {1'b0, amag_ramp, 1'b0};

    tmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    tmp_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_operand),
        .done    (sq_done),
        .root    (sq_root)
    );

    // phase choice for an update
    always_comb
    begin
        phase_next = PH_DECEL;
        if ($signed(rem_reg) <= $signed({3'b0, cfg.ptol}) && velocity_reg <= cfg.vtol)
        begin
            phase_next = PH_DONE;
        end
        else
        begin
            if (dist_reg < {2'b0, ramp_span_reg})
                phase_next = PH_ACCEL;
            else if (dist_reg < {1'b0, ramp_end})
                phase_next = PH_CRUISE;
            // early switch to braking
            if ($signed(rem_reg) <= $signed({3'b0, q_sat}))
                phase_next = PH_DECEL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_ACCEPT)
        begin
            pos_reg  <= in_data[33:2];
            dt_reg   <= in_data[49:34];
            vmax_reg <= mag32(cfg.vmax);
        end
        if (ctl.op == OP_UMUL)
        begin
            dist_reg <= d_abs;
            rem_reg  <= {3'b0, move_length_reg} - {1'b0, d_abs};
            step_reg <= step_prod[46:DT_FRAC];
        end
        if (ctl.op == OP_EMUL)
            est_reg <= 31'd0;
        if (ctl.op == OP_EFIN)
            est_reg <= q_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            velocity_reg    <= 31'd0;
            accel_out_reg   <= 32'd0;
            ramp_span_reg   <= 31'd0;
            cruise_span_reg <= 31'd0;
            peak_reg        <= 31'd0;
            move_length_reg <= 31'd0;
            accel_mag_reg   <= 31'd0;
        end
        else
        begin
            unique case (ctl.op)
                OP_ACCEPT:
                begin
                    if (in_data[1:0] == CMD_START)
                    begin
                        move_length_reg <= mag32(cfg.tdist);
                        accel_mag_reg   <= mag32(cfg.arate);
                        velocity_reg    <= 31'd0;
                        accel_out_reg   <= 32'd0;
                    end
                    else if (in_data[1:0] == CMD_IDLE)
                    begin
                        phase_reg       <= PH_IDLE;
                        velocity_reg    <= 31'd0;
                        accel_out_reg   <= 32'd0;
                        ramp_span_reg   <= 31'd0;
                        cruise_span_reg <= 31'd0;
                        peak_reg        <= 31'd0;
                        move_length_reg <= 31'd0;
                        accel_mag_reg   <= 31'd0;
                    end
                end
                OP_SFIN:
                begin
                    if (ramp_fits)
                    begin
                        ramp_span_reg   <= q_sat;
                        cruise_span_reg <= move_length_reg - {q_sat[29:0], 1'b0};
                        peak_reg        <= vmax_reg;
                    end
                    else
                    begin
                        ramp_span_reg   <= move_length_reg >> 1;
                        cruise_span_reg <= 31'd0;
                    end
                    if (move_length_reg > cfg.ptol)
                    begin
                        phase_reg     <= PH_ACCEL;
                        accel_out_reg <= {1'b0, accel_mag_reg};
                    end
                    else
                    begin
                        phase_reg <= PH_DONE;
                    end
                end
                OP_SQFIN:
                begin
                    peak_reg <= sq_root[30:0];
                end
                OP_UFIN:
                begin
                    phase_reg <= phase_next;
                end
                OP_UAPPLY:
                begin
                    unique case (phase_reg)
                        PH_ACCEL:
                        begin
                            velocity_reg  <= (vsum >= {1'b0, peak_reg}) ? peak_reg : vsum[30:0];
                            accel_out_reg <= {1'b0, accel_mag_reg};
                        end
                        PH_CRUISE:
                        begin
                            velocity_reg  <= peak_reg;
                            accel_out_reg <= 32'd0;
                        end
                        PH_DECEL:
                        begin
                            velocity_reg  <= (step_reg >= velocity_reg) ? 31'd0
                                             : velocity_reg - step_reg;
                            accel_out_reg <= 32'd0 - {1'b0, accel_mag_reg};
                        end
                        default:
                        begin
                            velocity_reg  <= 31'd0;
                            accel_out_reg <= 32'd0;
                        end
                    endcase
                end
                default:
                begin
                    phase_reg <= phase_reg;
                end
            endcase
        end
    end

    // output register, frees the controller from the receiver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (ctl.op == OP_OUT)
            m_valid_reg <= 1'b1;
        else if (out_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_OUT)
            m_data_reg <= {6'd0, est_reg, (phase_reg == PH_DONE), phase_reg,
                           accel_out_reg, velocity_reg};
    end

    assign sts.in_cmd    = in_data[1:0];
    assign sts.upd_run   = upd_run;
    assign sts.div_done  = div_done;
    assign sts.sq_done   = sq_done;
    assign sts.need_sqrt = !ramp_fits;
    assign sts.est_run   = est_run;
    assign sts.out_free  = !m_valid_reg || out_ready;

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;
endmodule

/* sv/tmp_ctrl.sv */
module tmp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tmp_pkg::sts_t sts,
    output tmp_pkg::cmd_t ctl
);
    import tmp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SMUL   = 4'd1;
    localparam logic [3:0] S_SDIV   = 4'd2;
    localparam logic [3:0] S_SFIN   = 4'd3;
    localparam logic [3:0] S_SQMUL  = 4'd4;
    localparam logic [3:0] S_SQRT   = 4'd5;
    localparam logic [3:0] S_SQFIN  = 4'd6;
    localparam logic [3:0] S_UMUL   = 4'd7;
    localparam logic [3:0] S_UDIV   = 4'd8;
    localparam logic [3:0] S_UFIN   = 4'd9;
    localparam logic [3:0] S_UAPPLY = 4'd10;
    localparam logic [3:0] S_EMUL   = 4'd11;
    localparam logic [3:0] S_EDIV   = 4'd12;
    localparam logic [3:0] S_EFIN   = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op = OP_ACCEPT;
                    if (sts.in_cmd == CMD_START)
                        state_next = S_SMUL;
                    else if (sts.in_cmd == CMD_UPDATE && sts.upd_run)
                        state_next = S_UMUL;
                    else
                        state_next = S_EMUL;
                end
            end
            S_SMUL:
            begin
                ctl.op     = OP_SMUL;
                state_next = S_SDIV;
            end
            S_SDIV:
            begin
                if (sts.div_done)
                    state_next = S_SFIN;
            end
            S_SFIN:
            begin
                ctl.op     = OP_SFIN;
                state_next = sts.need_sqrt ? S_SQMUL : S_EMUL;
            end
            S_SQMUL:
            begin
                ctl.op     = OP_SQMUL;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sts.sq_done)
                    state_next = S_SQFIN;
            end
            S_SQFIN:
            begin
                ctl.op     = OP_SQFIN;
                state_next = S_EMUL;
            end
            S_UMUL:
            begin
                ctl.op     = OP_UMUL;
                state_next = S_UDIV;
            end
            S_UDIV:
            begin
                if (sts.div_done)
                    state_next = S_UFIN;
            end
            S_UFIN:
            begin
                ctl.op     = OP_UFIN;
                state_next = S_UAPPLY;
            end
            S_UAPPLY:
            begin
                ctl.op     = OP_UAPPLY;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                ctl.op     = OP_EMUL;
                state_next = sts.est_run ? S_EDIV : S_OUT;
            end
            S_EDIV:
            begin
                if (sts.div_done)
                    state_next = S_EFIN;
            end
            S_EFIN:
            begin
                ctl.op     = OP_EFIN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

/* sv/trapezoidal_motion_profile_core.sv */
// Trapezoidal / triangular motion profile generator, Q16.16 fixed point.
// Input stream s_*: one transfer per command (start, update, return to idle,
// no-op). Output stream m_*: exactly one result transfer per input transfer,
// in order: velocity, acceleration, phase, done flag, remaining estimate.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while no item is in flight, which the block does not enforce;
// unknown indexes are ignored. One item is worked at a time; s_tready is
// high only while the controller waits for a command. The core uses one
// shared 64-step restoring divider (ramp span, braking distance, estimate)
// and a 32-step square-root unit.
// The result sits in an output register; a new item is accepted while it
// waits, but the next result is held back until m_tready takes the old one.
// Reset clears the move state to idle, velocity and acceleration to zero,
// registers to zero except the tolerances (2.0 and 30.0).
module trapezoidal_motion_profile_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0], position[33:2], time_step[49:34], zero fill
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // velocity_cmd[30:0], accel_cmd[62:31], phase_code[65:63], done_res[66],
    // remaining_estimate[97:67], zero fill
    output logic [103:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import tmp_pkg::*;

    localparam logic [30:0] PTOL_RST = 31'(2) << FRAC_BITS;
    localparam logic [30:0] VTOL_RST = 31'(30) << FRAC_BITS;

    cfg_t cfg_reg;
    cmd_t ctl;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tdist <= 32'd0;
            cfg_reg.vmax  <= 32'd0;
            cfg_reg.arate <= 32'd0;
            cfg_reg.spos  <= 32'd0;
            cfg_reg.ptol  <= PTOL_RST;
            cfg_reg.vtol  <= VTOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TDIST: cfg_reg.tdist <= cfg_wdata;
                REG_VMAX:  cfg_reg.vmax  <= cfg_wdata;
                REG_ARATE: cfg_reg.arate <= cfg_wdata;
                REG_SPOS:  cfg_reg.spos  <= cfg_wdata;
                REG_PTOL:  cfg_reg.ptol  <= cfg_wdata[30:0];
                REG_VTOL:  cfg_reg.vtol  <= cfg_wdata[30:0];
                default:   cfg_reg.spos  <= cfg_reg.spos;
            endcase
        end
    end

    tmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tmp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .cfg       (cfg_reg),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );
endmodule
